@@ rtl/core/mlfd_pkg.sv @@
// Shared types and constants of the magic and length frame decoder.
// Used by the front, queue, back and top level modules; depends on nothing.
package mlfd_pkg;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    PH_MAGIC = 3'b001,
    PH_LEN   = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  typedef enum logic {
    OP_ITEM   = 1'b0,
    OP_REJECT = 1'b1
  } op_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_PUSH    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ERR      = 2'd1;
  localparam logic [1:0] ST_NOT_MINE = 2'd2;

  localparam logic [1:0] LM_FIXED = 2'd0;
  localparam logic [1:0] LM_LEN16 = 2'd1;
  localparam logic [1:0] LM_LEN32 = 2'd2;

  localparam logic [2:0] CFG_MAGIC_BYTES = 3'd0;
  localparam logic [2:0] CFG_MAGIC_COUNT = 3'd1;
  localparam logic [2:0] CFG_LENGTH_MODE = 3'd2;
  localparam logic [2:0] CFG_MIN_LENGTH  = 3'd3;
  localparam logic [2:0] CFG_MAX_LENGTH  = 3'd4;
  localparam logic [2:0] CFG_PUSH_BACK   = 3'd5;

  typedef struct packed {
    logic [63:0] magic_bytes;
    logic [3:0]  magic_count;
    logic [1:0]  length_mode;
    logic [31:0] min_length;
    logic [31:0] max_length;
    logic        push_back_enable;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        last;
    logic [63:0] held;
    logic [3:0]  count;
  } entry_t;

endpackage

@@ rtl/core/mlfd_front.sv @@
// Front end of the frame decoder: takes stream bytes, tracks the header and body,
// and issues one queue entry per byte at most. Depends on mlfd_pkg.
module mlfd_front #(
  parameter int MAX_MAGIC = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mlfd_pkg::cfg_t       cfg,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  output logic                 push,
  output mlfd_pkg::entry_t     push_entry
);

  localparam logic [3:0] MagicCap = (MAX_MAGIC < 8) ? 4'(MAX_MAGIC) : 4'd8;

  mlfd_pkg::phase_t phase, phase_next;
  logic [3:0]  hidx, hidx_next;
  logic [63:0] held, held_next;
  logic [31:0] acc, acc_next;
  logic [31:0] remaining, remaining_next;

  logic [3:0]  mc;
  logic [2:0]  ls;
  logic [4:0]  hlen;
  logic [31:0] sb_acc;
  logic [32:0] flen;
  logic        sb_bad;
  logic        sb_empty;
  logic [31:0] sb_body;

  assign mc = (cfg.magic_count > MagicCap) ? MagicCap : cfg.magic_count;

  always_comb begin
    case (cfg.length_mode)
      mlfd_pkg::LM_LEN16: ls = 3'd2;
      mlfd_pkg::LM_LEN32: ls = 3'd4;
      default:            ls = 3'd0;
    endcase
  end

  assign hlen   = 5'(mc) + 5'(ls);
  assign sb_acc = (phase == mlfd_pkg::PH_MAGIC) ? {24'd0, in_byte} : {acc[23:0], in_byte};

  always_comb begin
    sb_bad = ({27'd0, hlen} > cfg.min_length) || (cfg.max_length < cfg.min_length);
    case (cfg.length_mode)
      mlfd_pkg::LM_FIXED: begin
        flen = {1'b0, cfg.min_length};
        if (cfg.min_length != cfg.max_length) sb_bad = 1'b1;
      end
      mlfd_pkg::LM_LEN16: begin
        flen = {17'd0, sb_acc[15:0]};
      end
      mlfd_pkg::LM_LEN32: begin
        flen = {28'd0, hlen} + {1'b0, sb_acc};
        if (flen[32]) sb_bad = 1'b1;
      end
      default: begin
        flen   = 33'd0;
        sb_bad = 1'b1;
      end
    endcase
    if ((flen < {1'b0, cfg.min_length}) || (flen > {1'b0, cfg.max_length})) sb_bad = 1'b1;
    sb_empty = (flen == {28'd0, hlen});
    sb_body  = flen[31:0] - {27'd0, hlen};
  end

  always_comb begin
    mlfd_pkg::phase_t ph;
    logic [3:0]  hx;
    logic [3:0]  hx_inc;
    logic [31:0] rem_cur;
    logic [31:0] rem_dec;
    logic [63:0] held_new;
    logic [63:0] mask;
    logic        dropped;

    phase_next     = phase;
    hidx_next      = hidx;
    held_next      = held;
    acc_next       = acc;
    remaining_next = remaining;
    push           = 1'b0;
    push_entry     = '0;
    push_entry.op  = mlfd_pkg::OP_ITEM;

    ph       = phase;
    hx       = hidx;
    rem_cur  = remaining;
    dropped  = 1'b0;
    hx_inc   = 4'd0;
    rem_dec  = 32'd0;
    held_new = held;
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = (4'(i) < mc) ? 8'hFF : 8'h00;
    end

    if (in_fire) begin
      if (ph == mlfd_pkg::PH_MAGIC && mc == 4'd0) begin
        ph = mlfd_pkg::PH_LEN;
        hx = 4'd0;
      end
      if (ph == mlfd_pkg::PH_LEN && ls == 3'd0) begin
        if (sb_bad || sb_empty) begin
          push              = 1'b1;
          push_entry.kind   = mlfd_pkg::KIND_END;
          push_entry.status = sb_bad ? mlfd_pkg::ST_ERR : mlfd_pkg::ST_OK;
          push_entry.last   = 1'b1;
          dropped           = 1'b1;
          phase_next        = mlfd_pkg::PH_MAGIC;
          hidx_next         = 4'd0;
          held_next         = '0;
          acc_next          = '0;
        end else begin
          ph      = mlfd_pkg::PH_BODY;
          rem_cur = sb_body;
        end
      end

      if (!dropped) begin
        hx_inc = hx + 4'd1;
        case (ph)
          mlfd_pkg::PH_MAGIC: begin
            if (hx < 4'd8) held_new[{hx[2:0], 3'b000} +: 8] = in_byte;
            held_next = held_new;
            hidx_next = hx_inc;
            if (hx_inc >= mc) begin
              phase_next = mlfd_pkg::PH_MAGIC;
              hidx_next  = 4'd0;
              held_next  = '0;
              acc_next   = '0;
              if (((held_new ^ cfg.magic_bytes) & mask) != 64'd0) begin
                push             = 1'b1;
                push_entry.op    = mlfd_pkg::OP_REJECT;
                push_entry.held  = held_new;
                push_entry.count = cfg.push_back_enable ? mc : 4'd0;
              end else if (ls != 3'd0) begin
                phase_next = mlfd_pkg::PH_LEN;
              end else if (sb_bad || sb_empty) begin
                push              = 1'b1;
                push_entry.kind   = mlfd_pkg::KIND_END;
                push_entry.status = sb_bad ? mlfd_pkg::ST_ERR : mlfd_pkg::ST_OK;
                push_entry.last   = 1'b1;
              end else begin
                phase_next     = mlfd_pkg::PH_BODY;
                remaining_next = sb_body;
              end
            end
          end
          mlfd_pkg::PH_LEN: begin
            phase_next = mlfd_pkg::PH_LEN;
            acc_next   = sb_acc;
            hidx_next  = hx_inc;
            if (hx_inc >= 4'(ls)) begin
              phase_next = mlfd_pkg::PH_MAGIC;
              hidx_next  = 4'd0;
              held_next  = '0;
              acc_next   = '0;
              if (sb_bad || sb_empty) begin
                push              = 1'b1;
                push_entry.kind   = mlfd_pkg::KIND_END;
                push_entry.status = sb_bad ? mlfd_pkg::ST_ERR : mlfd_pkg::ST_OK;
                push_entry.last   = 1'b1;
              end else begin
                phase_next     = mlfd_pkg::PH_BODY;
                remaining_next = sb_body;
              end
            end
          end
          mlfd_pkg::PH_BODY: begin
            rem_dec           = (rem_cur != 32'd0) ? rem_cur - 32'd1 : 32'd0;
            push              = 1'b1;
            push_entry.kind   = mlfd_pkg::KIND_PAYLOAD;
            push_entry.data   = in_byte;
            push_entry.status = mlfd_pkg::ST_OK;
            push_entry.last   = (rem_dec == 32'd0);
            remaining_next    = rem_dec;
            phase_next        = mlfd_pkg::PH_BODY;
            if (rem_dec == 32'd0) begin
              phase_next = mlfd_pkg::PH_MAGIC;
              hidx_next  = 4'd0;
              held_next  = '0;
              acc_next   = '0;
            end
          end
          default: begin
            phase_next = mlfd_pkg::PH_MAGIC;
            hidx_next  = 4'd0;
            held_next  = '0;
            acc_next   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mlfd_pkg::PH_MAGIC;
      hidx      <= 4'd0;
      held      <= '0;
      acc       <= '0;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      hidx      <= hidx_next;
      held      <= held_next;
      acc       <= acc_next;
      remaining <= remaining_next;
    end
  end

endmodule

@@ rtl/core/mlfd_queue.sv @@
// Short queue of decoder entries between the front and the back end.
// Depends on mlfd_pkg for the entry type and the depth.
module mlfd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mlfd_pkg::entry_t   push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output mlfd_pkg::entry_t   head
);

  localparam int PtrW = (mlfd_pkg::QUEUE_DEPTH > 1) ? $clog2(mlfd_pkg::QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(mlfd_pkg::QUEUE_DEPTH + 1);

  mlfd_pkg::entry_t slots [mlfd_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign full       = (fill == CntW'(mlfd_pkg::QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(mlfd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(mlfd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) fill <= fill + CntW'(1);
      else if (pop && !push) fill <= fill - CntW'(1);
    end
  end

endmodule

@@ rtl/core/mlfd_back.sv @@
// Back end of the frame decoder: turns queue entries into result transactions,
// expanding a magic rejection into its pushed-back bytes. Depends on mlfd_pkg.
module mlfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mlfd_pkg::entry_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic [1:0]         out_status,
  output logic               out_last
);

  logic [3:0] idx;
  logic       load;
  logic       pushing_byte;

  assign load         = !out_valid || out_ready;
  assign pushing_byte = (head.op == mlfd_pkg::OP_REJECT) && (idx < head.count);
  assign pop          = load && head_valid && !pushing_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid && head.op == mlfd_pkg::OP_REJECT) begin
        idx <= pushing_byte ? idx + 4'd1 : 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      case (head.op)
        mlfd_pkg::OP_ITEM: begin
          out_kind   <= head.kind;
          out_byte   <= head.data;
          out_status <= head.status;
          out_last   <= head.last;
        end
        mlfd_pkg::OP_REJECT: begin
          out_status <= mlfd_pkg::ST_NOT_MINE;
          if (pushing_byte) begin
            out_kind <= mlfd_pkg::KIND_PUSH;
            out_byte <= head.held[{idx[2:0], 3'b000} +: 8];
            out_last <= 1'b0;
          end else begin
            out_kind <= mlfd_pkg::KIND_END;
            out_byte <= 8'd0;
            out_last <= 1'b1;
          end
        end
        default: begin
          out_kind   <= mlfd_pkg::KIND_END;
          out_byte   <= 8'd0;
          out_status <= mlfd_pkg::ST_ERR;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/magic_length_frame_decoder_core.sv @@
// The decoder takes one stream byte per cycle while the queue is not full. Each accepted byte
// that yields an entry is written to a two-entry queue at once, and its result passes from
// the queue to the registered output of the back end. A payload byte gives one result
// transaction. A magic mismatch with push-back enabled holds the back end for one pushed-back
// byte per effective magic byte (magic_count capped at MAX_MAGIC and at 8) and then an end
// transaction, and input keeps flowing until the queue fills.
// Top level: configuration registers, front end, queue and back end. Depends on mlfd_pkg.
module magic_length_frame_decoder_core #(
  parameter int MAX_MAGIC = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [9:8] status, [15:10] zero
  output logic [1:0]  m_axis_tuser,  // [1:0] item_kind
  output logic        m_axis_tlast
);

  mlfd_pkg::cfg_t   cfg;
  mlfd_pkg::entry_t push_entry;
  mlfd_pkg::entry_t head;
  logic             push;
  logic             q_full;
  logic             pop;
  logic             head_valid;
  logic             in_fire;
  logic [7:0]       out_byte;
  logic [1:0]       out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mlfd_pkg::CFG_MAGIC_BYTES: cfg.magic_bytes      <= cfg_data;
        mlfd_pkg::CFG_MAGIC_COUNT: cfg.magic_count      <= cfg_data[3:0];
        mlfd_pkg::CFG_LENGTH_MODE: cfg.length_mode      <= cfg_data[1:0];
        mlfd_pkg::CFG_MIN_LENGTH:  cfg.min_length       <= cfg_data[31:0];
        mlfd_pkg::CFG_MAX_LENGTH:  cfg.max_length       <= cfg_data[31:0];
        mlfd_pkg::CFG_PUSH_BACK:   cfg.push_back_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  mlfd_front #(
    .MAX_MAGIC(MAX_MAGIC)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_byte   (s_axis_tdata),
    .push      (push),
    .push_entry(push_entry)
  );

  mlfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  mlfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_byte  (out_byte),
    .out_status(out_status),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_status, out_byte};

  assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("Queue entry written while the queue is full.");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == mlfd_pkg::KIND_PUSH |->
      !m_axis_tlast && out_status == mlfd_pkg::ST_NOT_MINE)
    else $error("Pushed-back magic byte with wrong status or end mark.");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == mlfd_pkg::KIND_PAYLOAD |-> out_status == mlfd_pkg::ST_OK)
    else $error("Payload transaction carries a non-OK status.");

endmodule
